### sv/assert_macros.svh
// Concurrent assertion helpers, empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SEP_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

`define SEP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`else

`define SEP_ASSERT(label, clk, rst_n, expr)

`define SEP_ASSERT_IMP(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/sep_pkg.sv
package sep_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int QUEUE_DEPTH         = 2;

    localparam int TIME_W     = 32;
    localparam int NEURON_W   = 24;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = TIME_W + NEURON_W;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = NEURON_W;
    localparam int M_TUSER_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLAYBACK_ACTIVE = 2'd0,
        REG_LOOP_ENABLE     = 2'd1,
        REG_LOOP_GRID       = 2'd2,
        REG_LOOP_DELAY      = 2'd3
    } reg_idx_t;

    typedef enum logic {
        KIND_ADD  = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [TIME_W-1:0]   ev_time;
        logic [NEURON_W-1:0] neuron;
    } cmd_t;

    typedef struct packed {
        logic              active;
        logic              loop_en;
        logic [CFG_W-1:0]  grid;
        logic [CFG_W-1:0]  delay;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]   ev_time;
        logic [NEURON_W-1:0] neuron;
    } entry_t;

    typedef struct packed {
        logic                spike;
        logic [NEURON_W-1:0] neuron;
        logic                full;
        logic                last;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_FULL,
        S_ADD_RD,
        S_ADD_CMP,
        S_ADD_RES,
        S_TICK_RD,
        S_TICK_CMP,
        S_TICK_FLUSH,
        S_DIV,
        S_DIV_END
    } state_t;

endpackage

### sv/spike_event_playback.sv
// Add: each later entry is read, compared and shifted up, then the new one is written; a full table just reports.
// Tick: each due entry is read and compared and its spike queued; inactive or empty playback only flushes.
// A tick that schedules a loop restart also computes the grid remainder bit-serially.
// A two-entry input queue takes new transactions while the engine works.
// Reset (rst_n low, asynchronous): empty table, clock and restart time at zero,
// playback active, looping off, grid 1, delay 0.
module spike_event_playback #(
    parameter int TABLE_DEPTH = sep_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sep_pkg::S_TDATA_W-1:0]   s_tdata,   // event_time, event_neuron
    input  logic [sep_pkg::S_TUSER_W-1:0]   s_tuser,   // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sep_pkg::M_TDATA_W-1:0]   m_tdata,   // spike_neuron
    output logic [sep_pkg::M_TUSER_W-1:0]   m_tuser,   // spike_valid, add_full
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [sep_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sep_pkg::CFG_W-1:0]       cfg_data
);
    import sep_pkg::*;

    cfg_t    cfg_reg;
    logic    q_valid;
    logic    q_ready;
    cmd_t    q_cmd;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active  <= 1'b1;
            cfg_reg.loop_en <= 1'b0;
            cfg_reg.grid    <= CFG_W'(1);
            cfg_reg.delay   <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_PLAYBACK_ACTIVE: cfg_reg.active  <= cfg_data[0];
                REG_LOOP_ENABLE:     cfg_reg.loop_en <= cfg_data[0];
                REG_LOOP_GRID:       cfg_reg.grid    <= cfg_data;
                REG_LOOP_DELAY:      cfg_reg.delay   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    sep_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    sep_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = res.neuron;
    assign m_tuser = {res.full, res.spike};
    assign m_tlast = res.last;

endmodule

### sv/sep_front.sv
module sep_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sep_pkg::S_TDATA_W-1:0]   s_tdata,   // event_time, event_neuron
    input  logic [sep_pkg::S_TUSER_W-1:0]   s_tuser,   // cmd
    output logic                            q_valid,
    input  logic                            q_ready,
    output sep_pkg::cmd_t                   q_cmd
);
    import sep_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           fifo_mem [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    cmd_t           in_cmd;
    logic           push;
    logic           pop;

    // classify the incoming transaction
    always_comb
    begin
        in_cmd.kind    = (s_tuser[0] == 1'b1) ? KIND_TICK : KIND_ADD;
        in_cmd.ev_time = s_tdata[TIME_W-1:0];
        in_cmd.neuron  = s_tdata[S_TDATA_W-1:TIME_W];
    end

    assign s_tready = (cnt_reg != QCW'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = fifo_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### sv/sep_engine.sv
`include "assert_macros.svh"

module sep_engine #(
    parameter int TABLE_DEPTH = sep_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sep_pkg::cfg_t     cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  sep_pkg::cmd_t     q_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output sep_pkg::result_t  out_res
);
    import sep_pkg::*;

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int DCW = $clog2(TIME_W);

    state_t              state_reg, state_next;

    entry_t              mem [TABLE_DEPTH];
    entry_t              rd_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    entry_t              mem_wd;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;

    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [TIME_W-1:0]   clock_reg, clock_next;
    logic [TIME_W-1:0]   base_reg, base_next;
    logic [TIME_W-1:0]   restart_reg, restart_next;
    logic [TIME_W-1:0]   offs_reg, offs_next;
    logic [TIME_W-1:0]   cur_time_reg, cur_time_next;
    logic [NEURON_W-1:0] cur_neuron_reg, cur_neuron_next;
    logic                tick_act_reg, tick_act_next;
    logic                pend_reg, pend_next;
    logic [NEURON_W-1:0] pend_neuron_reg, pend_neuron_next;

    logic [TIME_W-1:0]   div_r_reg, div_r_next;
    logic [TIME_W-1:0]   div_sh_reg, div_sh_next;
    logic [TIME_W-1:0]   div_rem_reg, div_rem_next;
    logic [TIME_W-1:0]   div_g_reg, div_g_next;
    logic [DCW-1:0]      div_cnt_reg, div_cnt_next;

    logic                out_valid_reg;
    result_t             out_res_reg;
    logic                push;
    result_t             push_res;

    logic                out_free;
    logic                table_full;
    logic                hit_restart;
    logic                ptr_in_table;
    logic                due;
    logic                loop_go;
    logic [TIME_W:0]     div_trial;
    logic [TIME_W:0]     div_diff;

    assign out_free     = !out_valid_reg || out_ready;
    assign table_full   = (count_reg == CW'(TABLE_DEPTH));
    assign hit_restart  = (clock_reg == restart_reg);
    assign ptr_in_table = (ptr_reg < count_reg);
    assign due          = (rd_reg.ev_time <= offs_reg);
    assign loop_go      = tick_act_reg && (ptr_reg == count_reg) &&
                          (restart_reg < clock_reg) && cfg.loop_en;
    assign div_trial    = {div_rem_reg, div_sh_reg[TIME_W-1]};
    assign div_diff     = div_trial - {1'b0, div_g_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.kind == KIND_ADD)
                    begin
                        state_next = table_full ? S_ADD_FULL : S_ADD_RD;
                    end
                    else
                    begin
                        state_next = (cfg.active && count_reg != '0) ? S_TICK_RD
                                                                    : S_TICK_FLUSH;
                    end
                end
            end
            S_ADD_FULL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ADD_RD:
            begin
                state_next = (idx_reg == '0) ? S_ADD_RES : S_ADD_CMP;
            end
            S_ADD_CMP:
            begin
                state_next = (rd_reg.ev_time > cur_time_reg) ? S_ADD_RD : S_ADD_RES;
            end
            S_ADD_RES:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK_RD:
            begin
                state_next = ptr_in_table ? S_TICK_CMP : S_TICK_FLUSH;
            end
            S_TICK_CMP:
            begin
                if (!due)
                begin
                    state_next = S_TICK_FLUSH;
                end
                else if (!pend_reg || out_free)
                begin
                    state_next = S_TICK_RD;
                end
            end
            S_TICK_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = loop_go ? S_DIV : S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and handshake outputs
    always_comb
    begin
        q_ready          = 1'b0;
        mem_we           = 1'b0;
        mem_wa           = idx_reg[AW-1:0];
        mem_wd           = rd_reg;
        mem_re           = 1'b0;
        mem_ra           = ptr_reg[AW-1:0];
        push             = 1'b0;
        push_res         = '0;
        push_res.last    = 1'b1;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        idx_next         = idx_reg;
        clock_next       = clock_reg;
        base_next        = base_reg;
        restart_next     = restart_reg;
        offs_next        = offs_reg;
        cur_time_next    = cur_time_reg;
        cur_neuron_next  = cur_neuron_reg;
        tick_act_next    = tick_act_reg;
        pend_next        = pend_reg;
        pend_neuron_next = pend_neuron_reg;
        div_r_next       = div_r_reg;
        div_sh_next      = div_sh_reg;
        div_rem_next     = div_rem_reg;
        div_g_next       = div_g_reg;
        div_cnt_next     = div_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                q_ready         = 1'b1;
                cur_time_next   = q_cmd.ev_time;
                cur_neuron_next = q_cmd.neuron;
                idx_next        = count_reg;
                tick_act_next   = cfg.active && (count_reg != '0);
                pend_next       = 1'b0;
                if (q_valid && q_cmd.kind == KIND_TICK && cfg.active && count_reg != '0)
                begin
                    if (hit_restart)
                    begin
                        ptr_next  = '0;
                        base_next = clock_reg;
                        offs_next = '0;
                    end
                    else
                    begin
                        offs_next = clock_reg - base_reg;
                    end
                end
            end
            S_ADD_FULL:
            begin
                push          = out_free;
                push_res.full = 1'b1;
            end
            S_ADD_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_wd     = '{ev_time: cur_time_reg, neuron: cur_neuron_reg};
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_ra = AW'(idx_reg - 1'b1);
                end
            end
            S_ADD_CMP:
            begin
                mem_we = 1'b1;
                if (rd_reg.ev_time > cur_time_reg)
                begin
                    mem_wd   = rd_reg;
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    mem_wd     = '{ev_time: cur_time_reg, neuron: cur_neuron_reg};
                    count_next = count_reg + 1'b1;
                end
            end
            S_ADD_RES:
            begin
                push = out_free;
            end
            S_TICK_RD:
            begin
                mem_re = ptr_in_table;
            end
            S_TICK_CMP:
            begin
                if (due && (!pend_reg || out_free))
                begin
                    push             = pend_reg;
                    push_res.spike   = 1'b1;
                    push_res.neuron  = pend_neuron_reg;
                    push_res.last    = 1'b0;
                    pend_next        = 1'b1;
                    pend_neuron_next = rd_reg.neuron;
                    ptr_next         = ptr_reg + 1'b1;
                end
            end
            S_TICK_FLUSH:
            begin
                push            = out_free;
                push_res.spike  = pend_reg;
                push_res.neuron = pend_reg ? pend_neuron_reg : '0;
                if (out_free)
                begin
                    pend_next = 1'b0;
                    if (loop_go)
                    begin
                        div_r_next   = clock_reg + cfg.delay;
                        div_sh_next  = clock_reg + cfg.delay;
                        div_rem_next = '0;
                        div_g_next   = (cfg.grid == '0) ? TIME_W'(1) : cfg.grid;
                        div_cnt_next = DCW'(TIME_W - 1);
                    end
                    else
                    begin
                        clock_next = clock_reg + 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                // one restoring step per cycle; only the remainder is kept
                div_sh_next  = {div_sh_reg[TIME_W-2:0], 1'b0};
                div_rem_next = div_diff[TIME_W] ? div_trial[TIME_W-1:0]
                                                : div_diff[TIME_W-1:0];
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            S_DIV_END:
            begin
                restart_next = (div_rem_reg == '0) ? div_r_reg
                                                   : div_r_reg - div_rem_reg + div_g_reg;
                clock_next   = clock_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            clock_reg     <= '0;
            base_reg      <= '0;
            restart_reg   <= '0;
            tick_act_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            idx_reg      <= idx_next;
            clock_reg    <= clock_next;
            base_reg     <= base_next;
            restart_reg  <= restart_next;
            tick_act_reg <= tick_act_next;
            pend_reg     <= pend_next;
            div_cnt_reg  <= div_cnt_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        offs_reg        <= offs_next;
        cur_time_reg    <= cur_time_next;
        cur_neuron_reg  <= cur_neuron_next;
        pend_neuron_reg <= pend_neuron_next;
        div_r_reg       <= div_r_next;
        div_sh_reg      <= div_sh_next;
        div_rem_reg     <= div_rem_next;
        div_g_reg       <= div_g_next;
        if (push)
        begin
            out_res_reg <= push_res;
        end
    end

    // event table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_ra];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    `SEP_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(TABLE_DEPTH))
    `SEP_ASSERT(a_ptr_bound, clk, rst_n, ptr_reg <= count_reg)
    `SEP_ASSERT_IMP(a_push_free, clk, rst_n, push, out_free)
    `SEP_ASSERT_IMP(a_idle_no_pend, clk, rst_n, state_reg == S_IDLE, !pend_reg)
    `SEP_ASSERT_IMP(a_div_grid, clk, rst_n, state_reg == S_DIV, div_g_reg != '0)

endmodule

### tb/tb_spike_event_playback.sv
module tb_spike_event_playback;
    timeunit 1ns;
    timeprecision 1ps;

    import sep_pkg::*;

    localparam int TBL_DEPTH    = DEFAULT_TABLE_DEPTH;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    spike_event_playback dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // playback state mirror
    logic [TIME_W-1:0]   tbl_time [0:TBL_DEPTH-1];
    logic [NEURON_W-1:0] tbl_neuron [0:TBL_DEPTH-1];
    logic [6:0]          tbl_count = '0;
    logic [6:0]          play_idx = '0;
    logic [31:0]         tick_clock = '0;
    logic [31:0]         time_base = '0;
    logic [31:0]         restart_at = '0;
    logic                cfg_active = 1'b1;
    logic                cfg_loop = 1'b0;
    logic [31:0]         cfg_grid = 32'd1;
    logic [31:0]         cfg_delay = '0;

    result_t             due_results [$];
    result_t             want_res;

    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          spikes_seen = 0;
    int          drops_seen = 0;
    int unsigned cycle_count = 0;

    int burst_left = 0;
    int gap_max = 0;
    int hold_req_count = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int ready_stretch = 0;
    int ready_stall_pct = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] align_restart(input logic [31:0] now);
        logic [63:0] g;
        logic [63:0] r;
        g = (cfg_grid == 32'd0) ? 64'd1 : {32'd0, cfg_grid};
        r = {32'd0, now + cfg_delay};
        if (r % g != 64'd0)
            r = (r / g + 64'd1) * g;
        return r[31:0];
    endfunction

    task automatic queue_result(input result_t r);
        due_results.insert(due_results.size(), r);
    endtask

    task automatic insert_event(input logic [31:0] t, input logic [23:0] n);
        result_t r;
        int pos;
        r = '0;
        r.last = 1'b1;
        if (tbl_count >= TBL_DEPTH)
            r.full = 1'b1;
        else
        begin
            pos = 0;
            while (pos < tbl_count && tbl_time[pos] <= t)
                pos++;
            for (int i = tbl_count; i > pos; i--)
            begin
                tbl_time[i] = tbl_time[i-1];
                tbl_neuron[i] = tbl_neuron[i-1];
            end
            tbl_time[pos] = t;
            tbl_neuron[pos] = n;
            tbl_count = tbl_count + 7'd1;
        end
        queue_result(r);
    endtask

    task automatic advance_tick();
        result_t r;
        logic [31:0] offs;
        logic have;
        r = '0;
        have = 1'b0;
        if (cfg_active && tbl_count > 0)
        begin
            if (tick_clock == restart_at)
            begin
                play_idx = '0;
                time_base = tick_clock;
            end
            offs = tick_clock - time_base;
            while (play_idx < tbl_count && tbl_time[play_idx] <= offs)
            begin
                if (have)
                    queue_result(r);
                r = '0;
                r.spike = 1'b1;
                r.neuron = tbl_neuron[play_idx];
                have = 1'b1;
                play_idx = play_idx + 7'd1;
            end
            if (play_idx >= tbl_count && restart_at < tick_clock && cfg_loop)
                restart_at = align_restart(tick_clock);
        end
        tick_clock = tick_clock + 32'd1;
        r.last = 1'b1;
        queue_result(r);
    endtask

    task automatic send_item(input kind_t k, input logic [31:0] t, input logic [23:0] n);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {n, t};
        s_tuser <= k;
        if (k == KIND_ADD)
            insert_event(t, n);
        else
            advance_tick();
        items_sent++;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PLAYBACK_ACTIVE: cfg_active = val[0];
            REG_LOOP_ENABLE:     cfg_loop = val[0];
            REG_LOOP_GRID:       cfg_grid = val;
            REG_LOOP_DELAY:      cfg_delay = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic active, input logic loop_on,
                             input logic [31:0] grid, input logic [31:0] delay);
        settle();
        write_reg(REG_PLAYBACK_ACTIVE, {31'd0, active});
        write_reg(REG_LOOP_ENABLE, {31'd0, loop_on});
        write_reg(REG_LOOP_GRID, grid);
        write_reg(REG_LOOP_DELAY, delay);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, $urandom, 24'($urandom));
    endtask

    task automatic test_quiet_ticks();
        gap_max = 3;
        repeat (2) send_tick();
    endtask

    task automatic test_basic_playback();
        send_item(KIND_ADD, 32'd2, 24'hFFFFFF);
        send_item(KIND_ADD, 32'd0, 24'h000000);
        send_item(KIND_ADD, 32'd2, 24'h5A5A5A);
        send_item(KIND_ADD, 32'd1, 24'h000001);
        send_item(KIND_ADD, 32'd6, 24'h800000);
        repeat (5) send_tick();
    endtask

    task automatic test_inactive();
        configure(1'b0, 1'b0, 32'd1, 32'd0);
        repeat (3) send_tick();
    endtask

    task automatic test_loop_wrap();
        // zero grid, delay wraps the restart below the clock
        configure(1'b1, 1'b1, 32'd0, 32'hFFFFFFFF);
        repeat (4) send_tick();
        send_item(KIND_ADD, 32'd3, 24'h0ABCDE);
        configure(1'b1, 1'b1, 32'd8, 32'd3);
        repeat (6) send_tick();
    endtask

    task automatic test_random_playback(input int n_items);
        logic [31:0] grid;
        grid = ($urandom_range(5) == 0) ? 32'd0 : $urandom_range(1, 16);
        configure($urandom_range(3) != 0, $urandom_range(4) != 0, grid,
                  $urandom_range(0, 24));
        gap_max = $urandom_range(0, 6);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(99) < 12 && tbl_count < 48)
                send_item(KIND_ADD, ($urandom_range(3) == 0) ? $urandom_range(0, 3)
                                                              : $urandom_range(0, 31),
                          24'($urandom));
            else
                send_tick();
        end
    endtask

    task automatic test_backpressure();
        configure(1'b1, 1'b1, 32'd4, 32'd0);
        gap_max = 0;
        hold_req_count++;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 10 == 5 && tbl_count < 48)
                send_item(KIND_ADD, $urandom_range(0, 31), 24'($urandom));
            else
                send_tick();
        end
    endtask

    task automatic test_extreme_loop();
        configure(1'b1, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        gap_max = 2;
        repeat (40) send_tick();
    endtask

    task automatic test_fill_table();
        configure(1'b1, 1'b0, 32'd1, 32'd0);
        gap_max = 4;
        send_item(KIND_ADD, 32'hFFFFFFFF, 24'h000000);
        send_item(KIND_ADD, 32'h00000000, 24'hFFFFFF);
        while (tbl_count < TBL_DEPTH)
            send_item(KIND_ADD, $urandom, 24'($urandom));
        repeat (3) send_item(KIND_ADD, $urandom, 24'($urandom));
        repeat (10) send_tick();
    endtask

    // receiver: random stall stretches, plus long hold on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_req_count)
        begin
            hold_seen = hold_req_count;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (ready_stretch == 0)
            begin
                ready_stretch = $urandom_range(5, 60);
                case ($urandom_range(4))
                    0, 1: ready_stall_pct = 0;
                    2:    ready_stall_pct = 30;
                    3:    ready_stall_pct = 70;
                    default: ready_stall_pct = 90;
                endcase
            end
            else
                ready_stretch--;
            m_tready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser[0])
                spikes_seen++;
            if (m_tuser[1])
                drops_seen++;
            if (due_results.size() == 0)
                flag_error($sformatf("unexpected result: spike %b neuron %h full %b last %b",
                                     m_tuser[0], m_tdata, m_tuser[1], m_tlast));
            else
            begin
                want_res = due_results.pop_front();
                if (m_tuser[0] !== want_res.spike || m_tdata !== want_res.neuron ||
                    m_tuser[1] !== want_res.full || m_tlast !== want_res.last)
                    flag_error($sformatf({"mismatch: expected spike %b neuron %h full %b last %b,",
                                          " got spike %b neuron %h full %b last %b"},
                                         want_res.spike, want_res.neuron, want_res.full,
                                         want_res.last, m_tuser[0], m_tdata, m_tuser[1],
                                         m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_quiet_ticks();
        test_basic_playback();
        test_inactive();
        test_loop_wrap();
        repeat (4) test_random_playback(50);
        test_backpressure();
        test_extreme_loop();
        test_fill_table();
        settle();

        $display("run covered %0d transactions in, %0d out: %0d spikes, %0d table-full drops",
                 items_sent, results_seen, spikes_seen, drops_seen);
        $display("playback on/off, looping with grid 0..max and delay 0..max, long output hold");
        if (mismatches == 0 && due_results.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches, %0d results never seen", mismatches, due_results.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
